/* rtl/lphm_pkg.sv */
// ----------------------------------------------------------------------------
// Hash map package
// Request and response codes, sequencer states and fixed widths of the
// linear probing hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int unsigned KEY_PORT_W = 64;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned LIMIT_W    = 9;
  localparam int unsigned HASH_SHIFT = 17;

  localparam logic [31:0]        HASH_MULT   = 32'hcc9e2d51;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd100;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_ZERO_KEY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_PROBE,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic                found;
    logic [VALUE_W-1:0]  value;
    logic [SLOT_W-1:0]   slot;
  } rsp_t;

endpackage

/* rtl/lphm_if.sv */
// ----------------------------------------------------------------------------
// Hash map channels
// Valid/ready channels for requests into and responses out of the hash map.
// ----------------------------------------------------------------------------
interface lphm_req_if
  import lphm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  action_e               action;
  logic [KEY_PORT_W-1:0] key;
  logic [VALUE_W-1:0]    value_in;

  modport source (output valid, action, key, value_in, input ready);
  modport sink (input valid, action, key, value_in, output ready);
endinterface

interface lphm_rsp_if
  import lphm_pkg::*;
();
  logic               valid;
  logic               ready;
  status_e            status;
  logic               found;
  logic [VALUE_W-1:0] value_out;
  logic [SLOT_W-1:0]  slot;

  modport source (output valid, status, found, value_out, slot, input ready);
  modport sink (input valid, status, found, value_out, slot, output ready);
endinterface

/* rtl/lphm_hash.sv */
// ----------------------------------------------------------------------------
// Home slot hash
// Multiplies the key by the hash constant, folds the product with its copy
// shifted right and yields the home slot in the cycle after the key is stable.
// ----------------------------------------------------------------------------
module lphm_hash
  import lphm_pkg::*;
#(
  parameter int unsigned IDX_W = 8
) (
  input  logic                  clk_i,
  input  logic [KEY_PORT_W-1:0] key_i,
  output logic [IDX_W-1:0]      home_o
);

  localparam int unsigned H_W = IDX_W + HASH_SHIFT;

  logic [63:0]    prod;
  logic [32:0]    h_low;
  logic [H_W-1:0] h_q;

  // Only product bits up to 32 reach the slot; the upper key half adds key bit 32.
  assign prod  = 64'(key_i[31:0]) * 64'(HASH_MULT);
  assign h_low = {prod[32] ^ key_i[32], prod[31:0]};

  always_ff @(posedge clk_i) begin
    h_q <= h_low[H_W-1:0];
  end

  assign home_o = h_q[IDX_W-1:0] ^ h_q[H_W-1:HASH_SHIFT];

endmodule

/* rtl/lphm_table.sv */
// ----------------------------------------------------------------------------
// Slot table
// Single write, single read memory of slot entries with registered read data.
// ----------------------------------------------------------------------------
module lphm_table
  import lphm_pkg::*;
#(
  parameter int unsigned IDX_W  = 8,
  parameter int unsigned DATA_W = 129
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [0:(1 << IDX_W)-1];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/linear_probe_hash_map.sv */
// ----------------------------------------------------------------------------
// Linear probing hash map
// Open addressing key/value table; lookup, insert, clear and no-op requests.
//
//   channel   dir   handshake        payload
//   req_i     in    valid / ready    action, key, value_in
//   rsp_o     out   valid / ready    status, found, value_out, slot
//   cfg       in    cfg_we_i         cfg_wdata_i (probe limit)
//
// Lookup or insert: accept, hash, home read, then probe one slot per cycle,
// then the response; the single table read port sets that pace.
// Clear: one table entry a cycle, all TABLE_SIZE of them, then the response.
// After reset a pass clears all TABLE_SIZE entries before req_i.ready.
// One request at a time: ready stays low until the response is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 256,
  parameter int unsigned KEY_WIDTH  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lphm_req_if.sink           req_i,
  lphm_rsp_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W  = (IDX_W + 1 > LIMIT_W) ? IDX_W + 1 : LIMIT_W;
  localparam int unsigned DATA_W = 1 + KEY_WIDTH + VALUE_W;

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     clr_q, clr_d;
  logic                 clr_rsp_q, clr_rsp_d;
  rsp_t                 rsp_q, rsp_d;
  logic [LIMIT_W-1:0]   limit_q;

  logic                 req_acc;
  logic [KEY_WIDTH-1:0] req_key;
  logic [CNT_W-1:0]     lim_eff;
  logic [CNT_W-1:0]     cnt_nx;
  logic [IDX_W-1:0]     idx_nx;
  logic [IDX_W-1:0]     home;
  logic                 clr_last;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [DATA_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [DATA_W-1:0]    mem_rdata;

  logic                 pr_valid;
  logic [KEY_WIDTH-1:0] pr_key;
  logic [VALUE_W-1:0]   pr_val;
  logic                 pr_empty;
  logic                 pr_hit;
  logic                 pr_last;

  lphm_hash #(
    .IDX_W (IDX_W)
  ) u_hash (
    .clk_i  (clk_i),
    .key_i  (KEY_PORT_W'(key_q)),
    .home_o (home)
  );

  lphm_table #(
    .IDX_W  (IDX_W),
    .DATA_W (DATA_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_acc  = req_i.valid && req_i.ready;
  assign req_key  = req_i.key[KEY_WIDTH-1:0];
  assign lim_eff  = (CNT_W'(limit_q) > CNT_W'(TABLE_SIZE)) ? CNT_W'(TABLE_SIZE)
                                                           : CNT_W'(limit_q);
  assign cnt_nx   = cnt_q + CNT_W'(1);
  assign idx_nx   = idx_q + IDX_W'(1);
  assign clr_last = (clr_q == IDX_W'(TABLE_SIZE - 1));

  assign {pr_valid, pr_key, pr_val} = mem_rdata;
  assign pr_empty = !pr_valid;
  assign pr_hit   = pr_valid && (pr_key == key_q);
  assign pr_last  = (cnt_nx == lim_eff);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) begin
          state_d = clr_rsp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          unique case (req_i.action)
            ACT_CLEAR: state_d = S_CLEAR;
            ACT_NONE:  state_d = S_RESP;
            default:   state_d = (req_key == '0) ? S_RESP : S_HASH;
          endcase
        end
      end
      S_HASH: state_d = S_HOME;
      S_HOME: state_d = (lim_eff == '0) ? S_RESP : S_PROBE;
      S_PROBE: begin
        if (pr_empty || pr_hit || pr_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    act_d     = act_q;
    key_d     = key_q;
    val_d     = val_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    clr_rsp_d = clr_rsp_q;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {1'b1, key_q, val_q};
    mem_raddr = idx_nx;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
      end
      S_IDLE: begin
        if (req_acc) begin
          act_d     = req_i.action;
          key_d     = req_key;
          val_d     = req_i.value_in;
          clr_d     = '0;
          clr_rsp_d = 1'b1;
          rsp_d     = '0;
          if ((req_i.action == ACT_LOOKUP || req_i.action == ACT_INSERT) &&
              req_key == '0) begin
            rsp_d.status = ST_ZERO_KEY;
          end
        end
      end
      S_HASH: ;
      S_HOME: begin
        mem_raddr = home;
        idx_d     = home;
        cnt_d     = '0;
        rsp_d     = '0;
        if (lim_eff == '0) begin
          rsp_d.status = ST_LIMIT;
        end
      end
      S_PROBE: begin
        if (pr_empty) begin
          if (act_q == ACT_INSERT) begin
            mem_we     = 1'b1;
            rsp_d.slot = SLOT_W'(idx_q);
          end else begin
            rsp_d.status = ST_NOT_FOUND;
          end
        end else if (pr_hit) begin
          mem_we      = (act_q == ACT_INSERT);
          rsp_d.found = 1'b1;
          rsp_d.value = pr_val;
          rsp_d.slot  = SLOT_W'(idx_q);
        end else if (pr_last) begin
          rsp_d.status = ST_LIMIT;
        end else begin
          idx_d = idx_nx;
          cnt_d = cnt_nx;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      clr_rsp_q <= 1'b0;
      limit_q   <= LIMIT_RESET;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_rsp_q <= clr_rsp_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    key_q <= key_d;
    val_q <= val_d;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    rsp_q <= rsp_d;
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = (state_q == S_RESP);
  assign rsp_o.status    = rsp_q.status;
  assign rsp_o.found     = rsp_q.found;
  assign rsp_o.value_out = rsp_q.value;
  assign rsp_o.slot      = rsp_q.slot;

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_PROBE))
    else $error("table written outside clear or probe");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while a response is pending");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (cnt_q < lim_eff))
    else $error("probe count past limit");

  a_home_after_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HASH) |=> (state_q == S_HOME))
    else $error("hash not followed by home read");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash map testbench
// Drives lookup, insert, clear and no-op requests into the linear probing
// hash map with random gaps and response stalls, predicts every response
// from a shadow table and compares each one field by field. It walks the
// probe limit from zero through the table size and beyond.
// ----------------------------------------------------------------------------
module tb;
  import lphm_pkg::*;

  localparam int TABLE_SIZE  = 256;
  localparam int POOL_SIZE   = 320;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 300;

  class hash_table_model;
    logic [LIMIT_W-1:0] probe_limit;
    logic [63:0]        key_at[TABLE_SIZE];
    logic [63:0]        value_at[TABLE_SIZE];
    bit                 occupied[TABLE_SIZE];
    rsp_t               pending_results[$];
    int                 n_mismatch;
    int                 n_results;
    int                 action_count[4];
    int                 status_count[4];

    function new();
      probe_limit = LIMIT_RESET;
      n_mismatch  = 0;
      n_results   = 0;
      for (int i = 0; i < TABLE_SIZE; i++) occupied[i] = 1'b0;
      for (int i = 0; i < 4; i++) begin
        action_count[i] = 0;
        status_count[i] = 0;
      end
    endfunction

    function logic [7:0] home_of(logic [63:0] k);
      logic [63:0] h;
      h = k * HASH_MULT;
      h = h ^ (h >> HASH_SHIFT);
      return h[7:0];
    endfunction

    function void note_request(action_e act, logic [63:0] k, logic [63:0] v);
      rsp_t e;
      int   lim;
      int   p;
      int   i;
      bit   done;
      e.status = ST_OK;
      e.found  = 1'b0;
      e.value  = '0;
      e.slot   = '0;
      action_count[act]++;
      if (act == ACT_CLEAR) begin
        for (i = 0; i < TABLE_SIZE; i++) occupied[i] = 1'b0;
      end else if (act != ACT_NONE) begin
        if (k == '0) begin
          e.status = ST_ZERO_KEY;
        end else begin
          lim = (probe_limit > TABLE_SIZE) ? TABLE_SIZE : int'(probe_limit);
          p = home_of(k);
          e.status = ST_LIMIT;
          done = 1'b0;
          for (i = 0; i < lim && !done; i++) begin
            if (!occupied[p]) begin
              if (act == ACT_LOOKUP) begin
                e.status = ST_NOT_FOUND;
              end else begin
                occupied[p] = 1'b1;
                key_at[p]   = k;
                value_at[p] = v;
                e.status    = ST_OK;
                e.slot      = 8'(p);
              end
              done = 1'b1;
            end else if (key_at[p] == k) begin
              e.status = ST_OK;
              e.found  = 1'b1;
              e.value  = value_at[p];
              e.slot   = 8'(p);
              if (act == ACT_INSERT) value_at[p] = v;
              done = 1'b1;
            end else begin
              p = (p + 1) % TABLE_SIZE;
            end
          end
        end
      end
      pending_results.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      n_results++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: response with no request outstanding: status %0d found %0b value %h slot %0d",
                   $realtime, got.status, got.found, got.value, got.slot);
        return;
      end
      e = pending_results.pop_front();
      status_count[e.status]++;
      if (got.status !== e.status || got.found !== e.found ||
          got.value !== e.value || got.slot !== e.slot) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: mismatch: expected status %0d found %0b value %h slot %0d, got status %0d found %0b value %h slot %0d",
                   $realtime, e.status, e.found, e.value, e.slot,
                   got.status, got.found, got.value, got.slot);
      end
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;

  lphm_req_if req_if ();
  lphm_rsp_if rsp_if ();

  linear_probe_hash_map u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  hash_table_model model;
  logic [63:0]     key_pool[POOL_SIZE];
  bit              tx_idle = 1'b1;
  bit              rx_idle = 1'b1;
  int              rx_hold = 0;
  int              n_settings = 1;
  int              quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or response moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : response_sink
    int   gap;
    rsp_t got;
    rsp_if.ready <= 1'b0;
    forever begin
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      got.status = rsp_if.status;
      got.found  = rsp_if.found;
      got.value  = rsp_if.value_out;
      got.slot   = rsp_if.slot;
      model.check_result(got);
    end
  end

  task automatic send_req(action_e act, logic [63:0] k, logic [63:0] v);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.key      <= k;
    req_if.value_in <= v;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    model.note_request(act, k, v);
  endtask

  task automatic set_probe_limit(logic [LIMIT_W-1:0] lim);
    req_if.valid <= 1'b0;
    while (model.pending_count() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model.probe_limit = lim;
    n_settings++;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] key_with_home(logic [7:0] home, logic [63:0] avoid);
    logic [63:0] k;
    do k = {$urandom, $urandom};
    while (k == '0 || k == avoid || model.home_of(k) != home);
    return k;
  endfunction

  task automatic run_random(int n_items, int hold_at);
    int          r;
    action_e     act;
    logic [63:0] k;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      if (i == hold_at) rx_hold = LONG_HOLD;
      r = $urandom_range(0, 999);
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 5) act = ACT_CLEAR;
      else if (r < 20) act = ACT_NONE;
      else act = ($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_LOOKUP;
      if (r >= 20 && r < 50) k = '0;
      else if (r >= 50 && r < 150) k = {$urandom, $urandom};
      send_req(act, k, {$urandom, $urandom});
    end
  endtask

  initial begin : stimulus
    logic [63:0]        key_a;
    logic [63:0]        key_b;
    logic [63:0]        key_c;
    logic [63:0]        key_d;
    logic [63:0]        key_e;
    logic [LIMIT_W-1:0] limits[7];
    int                 counts[7];

    model = new();
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    req_if.valid    <= 1'b0;
    req_if.action   <= ACT_LOOKUP;
    req_if.key      <= '0;
    req_if.value_in <= '0;

    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) key_pool[i] = key_with_home(8'($urandom_range(0, 15)), '0);
      else key_pool[i] = key_with_home(8'($urandom_range(0, 255)), '0);
    end
    key_a = key_with_home(8'd40, '0);
    key_b = key_with_home(8'd40, key_a);
    do key_c = key_with_home(8'd40, key_a); while (key_c == key_b);
    key_d = key_with_home(8'd255, '0);
    key_e = key_with_home(8'd255, key_d);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_req(ACT_LOOKUP, key_a, {$urandom, $urandom});
    send_req(ACT_INSERT, key_a, '0);
    send_req(ACT_INSERT, key_a, '1);
    send_req(ACT_LOOKUP, key_a, '0);
    send_req(ACT_INSERT, key_b, {$urandom, $urandom});
    send_req(ACT_LOOKUP, key_b, '0);
    send_req(ACT_LOOKUP, key_c, '0);
    send_req(ACT_LOOKUP, '0, '1);
    send_req(ACT_INSERT, '0, '1);
    send_req(ACT_INSERT, '1, {$urandom, $urandom});
    send_req(ACT_LOOKUP, '1, '0);
    send_req(ACT_NONE, key_a, '1);
    send_req(ACT_INSERT, 64'd1, '1);
    send_req(ACT_INSERT, key_d, {$urandom, $urandom});
    send_req(ACT_INSERT, key_e, {$urandom, $urandom});
    send_req(ACT_LOOKUP, key_e, '0);
    send_req(ACT_CLEAR, key_a, '1);
    send_req(ACT_LOOKUP, key_a, '0);
    send_req(ACT_INSERT, key_a, {$urandom, $urandom});

    limits = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd7, 9'd100, 9'($urandom_range(2, 255))};
    counts = '{300, 350, 100, 200, 300, 400, 350};
    for (int ph = 0; ph < 7; ph++) begin
      set_probe_limit(limits[ph]);
      run_random(counts[ph], (ph == 1) ? 40 : -1);
    end
    req_if.valid <= 1'b0;

    while (model.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d lookups, %0d inserts, %0d clears, %0d ignored requests over %0d probe limits",
             model.action_count[ACT_LOOKUP], model.action_count[ACT_INSERT],
             model.action_count[ACT_CLEAR], model.action_count[ACT_NONE], n_settings);
    $display("responses: %0d ok, %0d not found, %0d limit reached, %0d zero key; %0d mismatches",
             model.status_count[ST_OK], model.status_count[ST_NOT_FOUND],
             model.status_count[ST_LIMIT], model.status_count[ST_ZERO_KEY], model.n_mismatch);
    if (model.n_mismatch == 0 && model.pending_count() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
